// ===== sv/adcav_pkg.sv =====
// ----------------------------------------------------------------------------
// adcav_pkg
// Shared constants, register codes and types of the ADC averaging converter.
// ----------------------------------------------------------------------------
package adcav_pkg;

  localparam int AVG_LOG2    = 4;
  localparam int SAMPLE_BITS = 12;
  localparam int SUM_W       = SAMPLE_BITS + AVG_LOG2;
  localparam int CNT_W       = AVG_LOG2 + 1;
  localparam int BLOCK_LEN   = 1 << AVG_LOG2;

  // 312.167 * 3300 scaled by 1000, the pressure divisor per reference code.
  localparam longint PDEN_K      = 64'd1030151100;
  localparam longint MBAR_SCALE  = 64'd1000000;
  localparam int     MBAR_MAX    = 12000;
  localparam int     MV_MAX      = 8191;
  localparam int     CENTI_MIN   = 8000;
  localparam int     CENTI_MAX   = 30000;

  // Divider widths: dividend holds the pressure numerator, divisor its denominator.
  localparam int DIVD_W = 56;
  localparam int DIVS_W = 42;

  typedef enum logic [2:0] {
    REG_VREF_CAL_MV   = 3'd0,
    REG_VREF_CAL_CODE = 3'd1,
    REG_TEMP_CAL1_CODE = 3'd2,
    REG_TEMP_CAL2_CODE = 3'd3,
    REG_TEMP_CAL1_DEG = 3'd4,
    REG_TEMP_CAL2_DEG = 3'd5,
    REG_PRESSURE_ZERO = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [11:0]        vref_cal_mv;
    logic [11:0]        vref_cal_code;
    logic [11:0]        temp_cal1_code;
    logic [11:0]        temp_cal2_code;
    logic signed [8:0]  temp_cal1_deg;
    logic signed [8:0]  temp_cal2_deg;
    logic [11:0]        pressure_zero_code;
  } cfg_t;

  // One request handed from the front to the back.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pressure_avg;
    logic [SAMPLE_BITS-1:0] temp_avg;
    logic [SAMPLE_BITS-1:0] vref_avg;
    logic                   updated;
  } qentry_t;

endpackage

// ===== sv/adcav_in_if.sv =====
// ----------------------------------------------------------------------------
// adcav_in_if
// Scan channel: one request carries three raw ADC samples.
// ----------------------------------------------------------------------------
interface adcav_in_if;
  logic                             valid;
  logic                             ready;
  logic [adcav_pkg::SAMPLE_BITS-1:0] pressure_sample;
  logic [adcav_pkg::SAMPLE_BITS-1:0] temp_sample;
  logic [adcav_pkg::SAMPLE_BITS-1:0] vref_sample;

  modport source (output valid, pressure_sample, temp_sample, vref_sample, input ready);
  modport sink (input valid, pressure_sample, temp_sample, vref_sample, output ready);
endinterface

// ===== sv/adcav_out_if.sv =====
// ----------------------------------------------------------------------------
// adcav_out_if
// Result channel: converted pressure, supply and temperature.
// ----------------------------------------------------------------------------
interface adcav_out_if;
  logic               valid;
  logic               ready;
  logic [13:0]        pressure_mbar;
  logic [12:0]        supply_mv;
  logic signed [15:0] chip_temp_centideg;
  logic               averages_updated;
  logic               values_valid;

  modport source (output valid, pressure_mbar, supply_mv, chip_temp_centideg,
                  averages_updated, values_valid, input ready);
  modport sink (input valid, pressure_mbar, supply_mv, chip_temp_centideg,
                averages_updated, values_valid, output ready);
endinterface

// ===== sv/adcav_front.sv =====
// ----------------------------------------------------------------------------
// adcav_front
// Accepts scans, keeps the block sums and latches the block averages.
// ----------------------------------------------------------------------------
module adcav_front (
  input  logic               clk,
  input  logic               rst,
  adcav_in_if.sink           scan_in,
  input  logic               q_full,
  output logic               q_push,
  output adcav_pkg::qentry_t q_data
);
  import adcav_pkg::*;

  logic [CNT_W-1:0]       sample_count;
  logic [SUM_W-1:0]       pressure_sum, temp_sum, vref_sum;
  logic [SAMPLE_BITS-1:0] pressure_avg, temp_avg, vref_avg;
  logic                   block_done;
  logic [SAMPLE_BITS-1:0] p_avg_next, t_avg_next, v_avg_next;

  assign scan_in.ready = !q_full;
  assign q_push        = scan_in.valid && !q_full;
  assign block_done    = (sample_count >= CNT_W'(BLOCK_LEN));

  always_comb begin
    p_avg_next = block_done ? pressure_sum[SUM_W-1:AVG_LOG2] : pressure_avg;
    t_avg_next = block_done ? temp_sum[SUM_W-1:AVG_LOG2] : temp_avg;
    v_avg_next = block_done ? vref_sum[SUM_W-1:AVG_LOG2] : vref_avg;
    q_data.pressure_avg = p_avg_next;
    q_data.temp_avg     = t_avg_next;
    q_data.vref_avg     = v_avg_next;
    q_data.updated      = block_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      pressure_sum <= '0;
      temp_sum     <= '0;
      vref_sum     <= '0;
      pressure_avg <= '0;
      temp_avg     <= '0;
      vref_avg     <= '0;
    end else if (q_push) begin
      pressure_avg <= p_avg_next;
      temp_avg     <= t_avg_next;
      vref_avg     <= v_avg_next;
      if (block_done) begin
        sample_count <= CNT_W'(1);
        pressure_sum <= SUM_W'(scan_in.pressure_sample);
        temp_sum     <= SUM_W'(scan_in.temp_sample);
        vref_sum     <= SUM_W'(scan_in.vref_sample);
      end else begin
        sample_count <= sample_count + CNT_W'(1);
        pressure_sum <= pressure_sum + SUM_W'(scan_in.pressure_sample);
        temp_sum     <= temp_sum + SUM_W'(scan_in.temp_sample);
        vref_sum     <= vref_sum + SUM_W'(scan_in.vref_sample);
      end
    end
  end

endmodule

// ===== sv/adcav_fifo.sv =====
// ----------------------------------------------------------------------------
// adcav_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module adcav_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  adcav_pkg::qentry_t push_data,
  input  logic               pop,
  output adcav_pkg::qentry_t pop_data,
  output logic               full,
  output logic               not_empty
);
  import adcav_pkg::*;

  qentry_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== sv/adcav_div.sv =====
// ----------------------------------------------------------------------------
// adcav_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adcav_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [adcav_pkg::DIVD_W-1:0]   dividend,
  input  logic [adcav_pkg::DIVS_W-1:0]   divisor,
  output logic                           done,
  output logic [adcav_pkg::DIVD_W-1:0]   quotient
);
  import adcav_pkg::*;

  localparam int CW = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] dsr;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   diff;
  logic [CW-1:0]     cnt;
  logic              busy;

  assign rem_sh = {rem, quotient[DIVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      dsr      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[DIVS_W]) begin
        rem      <= diff[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DIVS_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/adcav_back.sv =====
// ----------------------------------------------------------------------------
// adcav_back
// Converts latched averages to supply, pressure and temperature results.
// ----------------------------------------------------------------------------
module adcav_back (
  input  logic               clk,
  input  logic               rst,
  input  adcav_pkg::cfg_t    cfg,
  input  logic               q_not_empty,
  input  adcav_pkg::qentry_t q_data,
  output logic               q_pop,
  adcav_out_if.source        result_out
);
  import adcav_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MUL1  = 10'b0000000010,
    ST_MUL2  = 10'b0000000100,
    ST_MUL3  = 10'b0000001000,
    ST_MUL4  = 10'b0000010000,
    ST_SIGN  = 10'b0000100000,
    ST_DIV_V = 10'b0001000000,
    ST_DIV_P = 10'b0010000000,
    ST_DIV_T = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  qentry_t job;

  logic [23:0]        calprod;
  logic [11:0]        pd;
  logic [23:0]        fa, fb;
  logic signed [12:0] dcode;
  logic signed [9:0]  ddeg;
  logic [31:0]        t1;
  logic [41:0]        pden;
  logic signed [25:0] tden;
  logic signed [24:0] frac;
  logic signed [15:0] d1h;
  logic signed [16:0] ddh;
  logic [55:0]        pnum;
  logic signed [42:0] ta, tb;
  logic signed [43:0] tnum;
  logic [43:0]        num_mag;
  logic [25:0]        den_mag;
  logic               t_neg;

  logic [13:0]        p_res;
  logic [12:0]        v_res;
  logic signed [15:0] t_res;
  logic               val_res;

  logic               issued;
  logic               div_start, div_done;
  logic [DIVD_W-1:0]  div_a, div_q;
  logic [DIVS_W-1:0]  div_b;
  logic               out_free;

  assign out_free = !result_out.valid || result_out.ready;
  assign q_pop    = (state == ST_IDLE) && q_not_empty;

  always_comb begin
    case (state)
      ST_DIV_V: begin
        div_a = DIVD_W'(calprod);
        div_b = DIVS_W'(job.vref_avg);
      end
      ST_DIV_P: begin
        div_a = pnum;
        div_b = pden;
      end
      default: begin
        div_a = DIVD_W'(num_mag);
        div_b = DIVS_W'(den_mag);
      end
    endcase
    div_start = !issued && ((state == ST_DIV_V) || (state == ST_DIV_P) ||
                            (state == ST_DIV_T));
  end

  adcav_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // Arithmetic registers: no stage chains one multiplication into another.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_pop) begin
          job <= q_data;
        end
      end
      ST_MUL1: begin
        calprod <= 24'(cfg.vref_cal_mv) * 24'(cfg.vref_cal_code);
        pd      <= (job.pressure_avg > cfg.pressure_zero_code) ?
                   job.pressure_avg - cfg.pressure_zero_code : 12'd0;
        fa      <= 24'(job.temp_avg) * 24'(cfg.vref_cal_code);
        fb      <= 24'(cfg.temp_cal1_code) * 24'(job.vref_avg);
        dcode   <= $signed({1'b0, cfg.temp_cal2_code}) - $signed({1'b0, cfg.temp_cal1_code});
        ddeg    <= 10'(cfg.temp_cal2_deg) - 10'(cfg.temp_cal1_deg);
      end
      ST_MUL2: begin
        t1   <= 32'(pd) * 32'(MBAR_SCALE);
        pden <= 42'(PDEN_K) * 42'(job.vref_avg);
        tden <= 26'(dcode) * $signed(26'({1'b0, job.vref_avg}));
        frac <= $signed({1'b0, fa}) - $signed({1'b0, fb});
        d1h  <= 16'(cfg.temp_cal1_deg) * 16'sd100;
        ddh  <= 17'(ddeg) * 17'sd100;
      end
      ST_MUL3: begin
        pnum <= 56'(t1) * 56'(calprod);
        ta   <= 43'(d1h) * 43'(tden);
        tb   <= 43'(ddh) * 43'(frac);
      end
      ST_MUL4: begin
        tnum <= 44'(ta) + 44'(tb);
      end
      ST_SIGN: begin
        num_mag <= tnum[43] ? 44'(-tnum) : 44'(tnum);
        den_mag <= tden[25] ? 26'(-tden) : 26'(tden);
        t_neg   <= tnum[43] ^ tden[25];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      issued            <= 1'b0;
      result_out.valid  <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      if (div_start) begin
        issued <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_MUL1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MUL3;
        ST_MUL3: state <= ST_MUL4;
        ST_MUL4: state <= ST_SIGN;
        ST_SIGN: begin
          p_res   <= '0;
          v_res   <= '0;
          t_res   <= '0;
          val_res <= 1'b0;
          state   <= (job.vref_avg == '0) ? ST_OUT : ST_DIV_V;
        end
        ST_DIV_V: begin
          if (div_done) begin
            issued <= 1'b0;
            v_res  <= (div_q > DIVD_W'(MV_MAX)) ? 13'(MV_MAX) : div_q[12:0];
            state  <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (div_done) begin
            issued <= 1'b0;
            p_res  <= (div_q > DIVD_W'(MBAR_MAX)) ? 14'(MBAR_MAX) : div_q[13:0];
            state  <= (cfg.temp_cal1_code == cfg.temp_cal2_code) ? ST_OUT : ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_done) begin
            issued  <= 1'b0;
            val_res <= 1'b1;
            if (t_neg) begin
              t_res <= (div_q > DIVD_W'(CENTI_MIN)) ? -16'sd8000 : -$signed(div_q[15:0]);
            end else begin
              t_res <= (div_q > DIVD_W'(CENTI_MAX)) ? 16'sd30000 : $signed(div_q[15:0]);
            end
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            result_out.valid <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      result_out.pressure_mbar      <= p_res;
      result_out.supply_mv          <= v_res;
      result_out.chip_temp_centideg <= t_res;
      result_out.averages_updated   <= job.updated;
      result_out.values_valid       <= val_res;
    end
  end

endmodule

// ===== sv/adc_average_pressure_temp_convert.sv =====
// ----------------------------------------------------------------------------
// adc_average_pressure_temp_convert
// Block-averaging ADC converter with internal-reference correction.
// ----------------------------------------------------------------------------
// A scan request on scan_in carries pressure, temperature and reference
// samples. Each scan adds to 16-sample block sums; the scan after a full
// block latches the new averages. Every scan yields one request on
// result_out with supply mV, pressure mbar, temperature in centidegrees
// and the updated and valid flags.
// Calibration is written over the APB port at byte address 4*index; the user
// must write it only while no scan is in flight, which the block itself does
// not enforce. Reads return the register value. In the back end a scan
// passes the idle state, where it is popped from the queue, the staged
// multiply states MUL1 to MUL4, the sign state, up to three passes through
// the shared restoring divider (56 quotient bits each) and the output state.
// The divider sets the rate. With a zero reference average it is skipped.
// A two-entry queue lets the front take scans while the back works, and
// the output register holds a result while the next one is computed; a
// stalled receiver backs up into the queue and then scan_in.ready drops.
// Reset restores the calibration defaults and clears sums and averages.
// ----------------------------------------------------------------------------
module adc_average_pressure_temp_convert (
  input  logic        clk,
  input  logic        rst,
  adcav_in_if.sink    scan_in,
  adcav_out_if.source result_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import adcav_pkg::*;

  cfg_t     cfg;
  reg_idx_t ridx;
  logic     q_push, q_pop, q_full, q_not_empty;
  qentry_t  q_in, q_out;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vref_cal_mv        <= 12'd3300;
      cfg.vref_cal_code      <= 12'd1500;
      cfg.temp_cal1_code     <= 12'd940;
      cfg.temp_cal2_code     <= 12'd1210;
      cfg.temp_cal1_deg      <= 9'sd30;
      cfg.temp_cal2_deg      <= 9'sd110;
      cfg.pressure_zero_code <= 12'd170;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_VREF_CAL_MV:    cfg.vref_cal_mv        <= pwdata[11:0];
        REG_VREF_CAL_CODE:  cfg.vref_cal_code      <= pwdata[11:0];
        REG_TEMP_CAL1_CODE: cfg.temp_cal1_code     <= pwdata[11:0];
        REG_TEMP_CAL2_CODE: cfg.temp_cal2_code     <= pwdata[11:0];
        REG_TEMP_CAL1_DEG:  cfg.temp_cal1_deg      <= $signed(pwdata[8:0]);
        REG_TEMP_CAL2_DEG:  cfg.temp_cal2_deg      <= $signed(pwdata[8:0]);
        REG_PRESSURE_ZERO:  cfg.pressure_zero_code <= pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_VREF_CAL_MV:    prdata = 32'(cfg.vref_cal_mv);
      REG_VREF_CAL_CODE:  prdata = 32'(cfg.vref_cal_code);
      REG_TEMP_CAL1_CODE: prdata = 32'(cfg.temp_cal1_code);
      REG_TEMP_CAL2_CODE: prdata = 32'(cfg.temp_cal2_code);
      REG_TEMP_CAL1_DEG:  prdata = 32'(cfg.temp_cal1_deg);
      REG_TEMP_CAL2_DEG:  prdata = 32'(cfg.temp_cal2_deg);
      REG_PRESSURE_ZERO:  prdata = 32'(cfg.pressure_zero_code);
      default:            prdata = '0;
    endcase
  end

  adcav_front u_front (
    .clk     (clk),
    .rst     (rst),
    .scan_in (scan_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  adcav_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  adcav_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .result_out  (result_out)
  );

endmodule

// ===== verif/adc_average_pressure_temp_convert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_average_pressure_temp_convert_tb
// Self-checking bench for the block-averaging ADC converter.
// ----------------------------------------------------------------------------
// Scans are driven on the scan channel under several calibration settings.
// Every accepted scan updates a software copy of the block sums and averages.
// That copy predicts the supply, pressure and temperature result, which is
// compared with the next result taken from the result channel.
// Calibration is rewritten over APB only while no result is outstanding.
// ----------------------------------------------------------------------------
module adc_average_pressure_temp_convert_tb;
  import adcav_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 3000;
  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 235;

  typedef struct packed {
    logic [13:0]        pressure_mbar;
    logic [12:0]        supply_mv;
    logic signed [15:0] chip_temp_centideg;
    logic               averages_updated;
    logic               values_valid;
  } conv_res_t;

  class conv_scoreboard;
    cfg_t        cfg;
    int unsigned p_sum, t_sum, v_sum, scan_cnt;
    bit [11:0]   p_avg, t_avg, v_avg;
    conv_res_t   pending[$];
    int          errors;

    function new();
      cfg.vref_cal_mv        = 12'd3300;
      cfg.vref_cal_code      = 12'd1500;
      cfg.temp_cal1_code     = 12'd940;
      cfg.temp_cal2_code     = 12'd1210;
      cfg.temp_cal1_deg      = 9'sd30;
      cfg.temp_cal2_deg      = 9'sd110;
      cfg.pressure_zero_code = 12'd170;
      p_sum = 0; t_sum = 0; v_sum = 0; scan_cnt = 0;
      p_avg = '0; t_avg = '0; v_avg = '0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Works out the result of one accepted scan request.
    function void note_scan(bit [11:0] p, bit [11:0] t, bit [11:0] v);
      conv_res_t r;
      longint calprod, mv, d, num, den, mb, dcode, ddeg, va, frac, tn, td, tt;
      r = '0;
      if (scan_cnt >= BLOCK_LEN) begin
        p_avg = 12'(p_sum >> AVG_LOG2);
        t_avg = 12'(t_sum >> AVG_LOG2);
        v_avg = 12'(v_sum >> AVG_LOG2);
        p_sum = 0; t_sum = 0; v_sum = 0; scan_cnt = 0;
        r.averages_updated = 1'b1;
      end
      p_sum += p; t_sum += t; v_sum += v;
      scan_cnt++;
      if (v_avg != 0) begin
        va = longint'(v_avg);
        calprod = longint'(cfg.vref_cal_mv) * longint'(cfg.vref_cal_code);
        mv = calprod / va;
        r.supply_mv = (mv > MV_MAX) ? 13'(MV_MAX) : 13'(mv);
        if (p_avg > cfg.pressure_zero_code) begin
          d = longint'(p_avg) - longint'(cfg.pressure_zero_code);
          num = d * MBAR_SCALE * calprod;
          den = PDEN_K * va;
          mb = num / den;
          r.pressure_mbar = (mb > MBAR_MAX) ? 14'(MBAR_MAX) : 14'(mb);
        end
        if (cfg.temp_cal1_code != cfg.temp_cal2_code) begin
          dcode = longint'(cfg.temp_cal2_code) - longint'(cfg.temp_cal1_code);
          ddeg = longint'(cfg.temp_cal2_deg) - longint'(cfg.temp_cal1_deg);
          frac = longint'(t_avg) * longint'(cfg.vref_cal_code)
               - longint'(cfg.temp_cal1_code) * va;
          td = dcode * va;
          tn = 100 * longint'(cfg.temp_cal1_deg) * td + 100 * ddeg * frac;
          if (td < 0) begin
            td = -td;
            tn = -tn;
          end
          tt = tn / td;
          if (tt < -CENTI_MIN) tt = -CENTI_MIN;
          if (tt > CENTI_MAX) tt = CENTI_MAX;
          r.chip_temp_centideg = 16'(tt);
          r.values_valid = 1'b1;
        end
      end
      pending.push_back(r);
    endfunction

    task check_result(conv_res_t got);
      conv_res_t exp_r;
      if (pending.size() == 0) begin
        report("result with no scan outstanding");
        return;
      end
      exp_r = pending.pop_front();
      if (got.pressure_mbar !== exp_r.pressure_mbar)
        report($sformatf("pressure_mbar got %0d exp %0d",
                         got.pressure_mbar, exp_r.pressure_mbar));
      if (got.supply_mv !== exp_r.supply_mv)
        report($sformatf("supply_mv got %0d exp %0d", got.supply_mv, exp_r.supply_mv));
      if (got.chip_temp_centideg !== exp_r.chip_temp_centideg)
        report($sformatf("chip_temp_centideg got %0d exp %0d",
                         got.chip_temp_centideg, exp_r.chip_temp_centideg));
      if (got.averages_updated !== exp_r.averages_updated)
        report($sformatf("averages_updated got %0b exp %0b",
                         got.averages_updated, exp_r.averages_updated));
      if (got.values_valid !== exp_r.values_valid)
        report($sformatf("values_valid got %0b exp %0b",
                         got.values_valid, exp_r.values_valid));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  adcav_in_if  scan();
  adcav_out_if result();

  adc_average_pressure_temp_convert i_dut (
    .clk       (clk),
    .rst       (rst),
    .scan_in   (scan),
    .result_out(result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  conv_scoreboard conv_sb = new();
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  logic           hold_on;
  bit             hold_start;
  int unsigned    quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    scan.valid = 1'b0;
    scan.pressure_sample = '0; scan.temp_sample = '0; scan.vref_sample = '0;
    result.ready = 1'b0;
    hold_on = 1'b0; hold_start = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
  end

  // The long receiver hold-off that lets the block fill up.
  initial begin
    wait (hold_start);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Monitors both channels, drives the receiver and runs the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (scan.valid && scan.ready)
        conv_sb.note_scan(scan.pressure_sample, scan.temp_sample, scan.vref_sample);
      if (result.valid && result.ready)
        conv_sb.check_result({result.pressure_mbar, result.supply_mv,
                              result.chip_temp_centideg, result.averages_updated,
                              result.values_valid});
      if ((scan.valid && scan.ready) || (result.valid && result.ready) ||
          (psel && penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
    result.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
  end

  task apb_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_VREF_CAL_MV:    conv_sb.cfg.vref_cal_mv = value[11:0];
      REG_VREF_CAL_CODE:  conv_sb.cfg.vref_cal_code = value[11:0];
      REG_TEMP_CAL1_CODE: conv_sb.cfg.temp_cal1_code = value[11:0];
      REG_TEMP_CAL2_CODE: conv_sb.cfg.temp_cal2_code = value[11:0];
      REG_TEMP_CAL1_DEG:  conv_sb.cfg.temp_cal1_deg = value[8:0];
      REG_TEMP_CAL2_DEG:  conv_sb.cfg.temp_cal2_deg = value[8:0];
      REG_PRESSURE_ZERO:  conv_sb.cfg.pressure_zero_code = value[11:0];
      default: ;
    endcase
  endtask

  // Presents one scan request and returns once it has been accepted.
  task send_scan(logic [11:0] p, logic [11:0] t, logic [11:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      scan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    scan.valid <= 1'b1;
    scan.pressure_sample <= p;
    scan.temp_sample <= t;
    scan.vref_sample <= v;
    do @(posedge clk); while (!scan.ready);
  endtask

  // Called right at the edge that accepted the last request.
  task wait_drained();
    scan.valid <= 1'b0;
    while (conv_sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task load_calibration(int phase);
    logic [11:0] val[7];
    case (phase)
      1: val = '{12'd3000, 12'd0, 12'd0, 12'd4095, 12'h1D8, 12'd150, 12'd0};
      2: val = '{12'd4095, 12'd4095, 12'd4095, 12'd0, 12'h0FF, 12'h100, 12'd4095};
      3: val = '{12'd3600, 12'd1500, 12'd1000, 12'd1000, 12'd25, 12'd85, 12'd170};
      default: begin
        val[0] = 12'($urandom_range(3600, 3000));
        val[1] = 12'($urandom_range(4095));
        val[2] = 12'($urandom_range(4095));
        val[3] = 12'($urandom_range(4095));
        val[4] = 12'($signed($urandom_range(190)) - 40) & 12'h1FF;
        val[5] = 12'($signed($urandom_range(190)) - 40) & 12'h1FF;
        val[6] = 12'($urandom_range(4095));
        if (phase % 3 == 0) begin
          val[0] = 12'($urandom_range(4095));
          val[4] = 12'($urandom_range(511));
          val[5] = 12'($urandom_range(511));
        end
      end
    endcase
    for (int i = 0; i < 7; i++) apb_write(reg_idx_t'(i), {20'd0, val[i]});
  endtask

  function automatic logic [11:0] pick_sample(int kind, logic [11:0] level);
    case (kind)
      0: return 12'($urandom_range(4095));
      1: return 12'(level + $urandom_range(15));
      2: return 12'($urandom_range(3));
      default: return 12'(4095 - $urandom_range(3));
    endcase
  endfunction

  initial begin
    logic [11:0] p_lvl, t_lvl, v_lvl;
    int          kind;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset calibration: the first block runs with a zero reference average,
    // then a tiny reference saturates the supply, then all-zero samples.
    for (int i = 0; i < 17; i++) send_scan(12'd4095, (i % 2) ? 12'd4095 : 12'd0, 12'd1);
    for (int i = 0; i < 8; i++) send_scan(12'd0, 12'd0, 12'd0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_calibration(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 4) hold_start = 1'b1;
      kind = 1; p_lvl = '0; t_lvl = '0; v_lvl = '0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Levels and the sample style change every BLOCK_LEN + 1 scans.
        if (i % (BLOCK_LEN + 1) == 0) begin
          kind = $urandom_range(9) < 6 ? 1 : int'($urandom_range(3));
          p_lvl = 12'($urandom_range(4095));
          t_lvl = 12'($urandom_range(4095));
          v_lvl = ($urandom_range(3) == 0) ? 12'($urandom_range(15)) : 12'($urandom_range(4095));
        end
        send_scan(pick_sample(kind, p_lvl), pick_sample(kind, t_lvl),
                  pick_sample(kind, v_lvl));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (conv_sb.pending.size() != 0)
      conv_sb.report("results still outstanding at end of run");
    if (conv_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
